>>> src/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

  // Request type codes on the input channel.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Final status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ID_ERR   = 2'd1;
  localparam logic [1:0] ST_SUM_ERR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_TIMEOUT   = 1'd1;
  localparam logic [15:0] HEADER_TIMEOUT_RST = 16'd250;
  localparam logic [15:0] BODY_TIMEOUT_RST   = 16'd3000;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] packet_id;
    logic [7:0]  rx_byte;
  } cpr_in_t;

  // One result on the output channel.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic [15:0] payload_length;
    logic        last;
  } cpr_out_t;

  // Timeout limits handed to the parser.
  typedef struct packed {
    logic [15:0] header_timeout;
    logic [15:0] body_timeout;
  } cpr_cfg_t;

endpackage

`default_nettype wire

>>> src/cpr_core.sv
`default_nettype none

module cpr_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire cpr_pkg::cpr_in_t item,
  input  wire cpr_pkg::cpr_cfg_t cfg,
  output logic                  res_valid,
  output cpr_pkg::cpr_out_t     res,
  output logic                  busy
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_BODY,
    PH_SUMH
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] expected_id_r, expected_id_nxt;
  logic [15:0] payload_size_r, payload_size_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  sum_low_r, sum_low_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;

  logic [15:0] sum_add;
  logic [15:0] tick_inc;
  logic [15:0] limit;

  assign busy = (phase_r != PH_IDLE);

  // Shared arithmetic: byte added to the running checksum, saturating tick count.
  assign sum_add  = running_sum_r + {8'h00, item.rx_byte};
  assign tick_inc = (tick_count_r == 16'hffff) ? tick_count_r : tick_count_r + 16'd1;
  assign limit    = (phase_r == PH_HEAD) ? cfg.header_timeout : cfg.body_timeout;

  // Parser next state and the result for the request in the input register.
  always_comb begin
    phase_nxt        = phase_r;
    expected_id_nxt  = expected_id_r;
    payload_size_nxt = payload_size_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    sum_low_nxt      = sum_low_r;
    tick_count_nxt   = tick_count_r;
    res_valid        = 1'b0;
    res              = '0;
    res.kind         = cpr_pkg::KIND_STATUS;
    res.last         = 1'b1;

    if (fire) begin
      case (item.req_type)
        cpr_pkg::REQ_START: begin
          expected_id_nxt  = item.packet_id;
          phase_nxt        = PH_HEAD;
          payload_size_nxt = '0;
          byte_count_nxt   = '0;
          running_sum_nxt  = '0;
          sum_low_nxt      = '0;
          tick_count_nxt   = '0;
        end
        cpr_pkg::REQ_BYTE: begin
          unique case (phase_r)
            PH_HEAD: begin
              // Header bytes: id low, id high, size low, size high.
              running_sum_nxt = sum_add;
              byte_count_nxt  = byte_count_r + 16'd1;
              case (byte_count_r[1:0])
                2'd0: payload_size_nxt = {8'h00, item.rx_byte};
                2'd1: sum_low_nxt =
                  {7'd0, ({item.rx_byte, payload_size_r[7:0]} != expected_id_r)};
                2'd2: payload_size_nxt = {8'h00, item.rx_byte};
                default: begin
                  payload_size_nxt = {item.rx_byte, payload_size_r[7:0]};
                  byte_count_nxt   = byte_count_r;
                  if (sum_low_r[0]) begin
                    res_valid          = 1'b1;
                    res.status         = cpr_pkg::ST_ID_ERR;
                    res.payload_length = {item.rx_byte, payload_size_r[7:0]};
                    phase_nxt          = PH_IDLE;
                  end else begin
                    phase_nxt      = PH_BODY;
                    byte_count_nxt = '0;
                    tick_count_nxt = '0;
                    sum_low_nxt    = '0;
                  end
                end
              endcase
            end
            PH_BODY: begin
              if (byte_count_r < payload_size_r) begin
                // Payload byte goes out as it arrives.
                running_sum_nxt    = sum_add;
                byte_count_nxt     = byte_count_r + 16'd1;
                res_valid          = 1'b1;
                res.kind           = cpr_pkg::KIND_DATA;
                res.last           = 1'b0;
                res.data_byte      = item.rx_byte;
                res.byte_index     = byte_count_r;
                res.payload_length = payload_size_r;
              end else begin
                sum_low_nxt = item.rx_byte;
                phase_nxt   = PH_SUMH;
              end
            end
            PH_SUMH: begin
              res_valid          = 1'b1;
              res.payload_length = payload_size_r;
              res.status = (running_sum_r == {item.rx_byte, sum_low_r}) ?
                           cpr_pkg::ST_OK : cpr_pkg::ST_SUM_ERR;
              phase_nxt          = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        cpr_pkg::REQ_TICK: begin
          if (phase_r != PH_IDLE) begin
            tick_count_nxt = tick_inc;
            if (tick_inc >= limit) begin
              res_valid          = 1'b1;
              res.status         = cpr_pkg::ST_TIMEOUT;
              res.payload_length = (phase_r == PH_HEAD) ? 16'd0 : payload_size_r;
              phase_nxt          = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      expected_id_r  <= '0;
      payload_size_r <= '0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      sum_low_r      <= '0;
      tick_count_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      expected_id_r  <= expected_id_nxt;
      payload_size_r <= payload_size_nxt;
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      sum_low_r      <= sum_low_nxt;
      tick_count_r   <= tick_count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/camera_packet_receiver.sv
// Channel  Ports                                  Moves
// in       in_valid, in_ready, in_data            start, received byte or tick request
// out      out_valid, out_ready, out_data         payload byte or final status
// cfg      cfg_we, cfg_addr, cfg_wdata            timeout limit writes, no wait
//
// One request per cycle is sustained while the output is not stalled: a request is
// held in the input register, the parser updates its state and the result enters
// the output register, from which it is presented.
// Reset is synchronous and active low; it idles the parser and restores the
// default timeout limits. A stalled output register holds the input register,
// and in_ready follows out_ready within the same cycle.
`default_nettype none

module camera_packet_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire cpr_pkg::cpr_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output cpr_pkg::cpr_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [15:0]                     cfg_wdata
);

  cpr_pkg::cpr_cfg_t cfg_r;
  logic              in_valid_r;
  cpr_pkg::cpr_in_t  in_item_r;
  logic              out_valid_r;
  cpr_pkg::cpr_out_t out_item_r;

  logic              fire;
  logic              res_valid;
  cpr_pkg::cpr_out_t res;
  logic              busy;

  // The parser takes the held request whenever the output register can accept.
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Timeout limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_timeout <= cpr_pkg::HEADER_TIMEOUT_RST;
      cfg_r.body_timeout   <= cpr_pkg::BODY_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cpr_pkg::CFG_HEADER_TIMEOUT: cfg_r.header_timeout <= cfg_wdata;
        cpr_pkg::CFG_BODY_TIMEOUT:   cfg_r.body_timeout   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  cpr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .busy      (busy)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_item_r <= res;
    end
  end

`ifndef SYNTHESIS
  // A final status always closes the packet, so the parser is idle afterwards.
  a_status_idles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.last |=> !busy)
    else $error("parser still busy after a final status");

  // A held request is neither lost nor overwritten while the output stalls.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_item_r))
    else $error("input register changed while stalled");

  // Payload bytes always fall inside the announced payload.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.kind == cpr_pkg::KIND_DATA) |->
      (out_item_r.byte_index < out_item_r.payload_length) && !out_item_r.last)
    else $error("payload byte index outside payload");

  // Status results carry last and no data.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.kind == cpr_pkg::KIND_STATUS) |->
      out_item_r.last && (out_item_r.data_byte == 8'd0) &&
      (out_item_r.byte_index == 16'd0))
    else $error("malformed status result");
`endif

endmodule

`default_nettype wire

>>> dv/tb_camera_packet_receiver.sv
`timescale 1ns / 1ps

module tb_camera_packet_receiver;

  localparam int CYCLE_LIMIT = 1_000_000;
  // A request's result passes the input register and then the output register.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_REQS = 450;

  // The block ignores this request code.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Ways to spoil the checksum of a queued packet.
  localparam int FAULT_NONE     = 0;
  localparam int FAULT_SUM_LOW  = 1;
  localparam int FAULT_SUM_HIGH = 2;
  localparam int NO_CUT = -1;

  typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_BODY, RX_SUM_HIGH} rx_phase_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  cpr_pkg::cpr_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  cpr_pkg::cpr_out_t             out_data;
  logic                          cfg_we = 1'b0;
  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [15:0]                   cfg_wdata = '0;

  camera_packet_receiver dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the packet parser and its timeout limits.
  logic [15:0] hdr_limit = cpr_pkg::HEADER_TIMEOUT_RST;
  logic [15:0] body_limit = cpr_pkg::BODY_TIMEOUT_RST;
  rx_phase_t   rx_phase = RX_IDLE;
  logic [15:0] want_id = '0;
  logic [7:0]  id_low = '0;
  logic        id_bad = 1'b0;
  logic [15:0] pkt_size = '0;
  logic [15:0] pkt_count = '0;
  logic [15:0] pkt_sum = '0;
  logic [7:0]  sum_low_rx = '0;
  logic [15:0] tick_count = '0;

  cpr_pkg::cpr_in_t  camera_req_q[$];
  cpr_pkg::cpr_out_t pkt_result_q[$];
  int       reqs_queued = 0;
  int       reqs_taken = 0;
  int       err_count = 0;
  int       cycle_count = 0;
  bit       no_idle = 1'b0;
  int       in_gap = 0;
  int       out_stall = 0;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic void expect_result(logic kind, logic [7:0] data, logic [15:0] idx,
                                        logic [1:0] st, logic [15:0] len);
    cpr_pkg::cpr_out_t r;
    r.kind = kind;
    r.data_byte = data;
    r.byte_index = idx;
    r.status = st;
    r.payload_length = len;
    r.last = (kind == cpr_pkg::KIND_STATUS);
    pkt_result_q.push_back(r);
  endfunction

  // Advances the predicted parser by one accepted request.
  task automatic parse_request(input cpr_pkg::cpr_in_t req);
    logic [15:0] limit;
    case (req.req_type)
      cpr_pkg::REQ_START: begin
        want_id = req.packet_id;
        rx_phase = RX_HEADER;
        pkt_size = '0;
        pkt_count = '0;
        pkt_sum = '0;
        id_bad = 1'b0;
        tick_count = '0;
      end
      cpr_pkg::REQ_BYTE: begin
        case (rx_phase)
          RX_HEADER: begin
            pkt_sum = pkt_sum + {8'h00, req.rx_byte};
            case (pkt_count)
              16'd0: id_low = req.rx_byte;
              16'd1: id_bad = ({req.rx_byte, id_low} != want_id);
              16'd2: pkt_size = {8'h00, req.rx_byte};
              default: begin
                pkt_size[15:8] = req.rx_byte;
                if (id_bad) begin
                  expect_result(cpr_pkg::KIND_STATUS, 8'h00, 16'h0000,
                                cpr_pkg::ST_ID_ERR, pkt_size);
                  rx_phase = RX_IDLE;
                end else begin
                  rx_phase = RX_BODY;
                  tick_count = '0;
                end
              end
            endcase
            pkt_count = (rx_phase == RX_HEADER) ? pkt_count + 16'd1 : 16'd0;
          end
          RX_BODY: begin
            if (pkt_count < pkt_size) begin
              pkt_sum = pkt_sum + {8'h00, req.rx_byte};
              expect_result(cpr_pkg::KIND_DATA, req.rx_byte, pkt_count, cpr_pkg::ST_OK,
                            pkt_size);
              pkt_count = pkt_count + 16'd1;
            end else begin
              sum_low_rx = req.rx_byte;
              rx_phase = RX_SUM_HIGH;
            end
          end
          RX_SUM_HIGH: begin
            expect_result(cpr_pkg::KIND_STATUS, 8'h00, 16'h0000,
                          ({req.rx_byte, sum_low_rx} == pkt_sum) ?
                          cpr_pkg::ST_OK : cpr_pkg::ST_SUM_ERR,
                          pkt_size);
            rx_phase = RX_IDLE;
          end
          default: ;
        endcase
      end
      cpr_pkg::REQ_TICK: begin
        if (rx_phase != RX_IDLE) begin
          if (tick_count != 16'hffff) tick_count = tick_count + 16'd1;
          limit = (rx_phase == RX_HEADER) ? hdr_limit : body_limit;
          if (tick_count >= limit) begin
            expect_result(cpr_pkg::KIND_STATUS, 8'h00, 16'h0000, cpr_pkg::ST_TIMEOUT,
                          (rx_phase == RX_HEADER) ? 16'h0000 : pkt_size);
            rx_phase = RX_IDLE;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Fields a request does not use carry random values.
  function automatic void push_req(logic [1:0] kind, logic [15:0] id, logic [7:0] b);
    cpr_pkg::cpr_in_t r;
    r.req_type = kind;
    r.packet_id = (kind == cpr_pkg::REQ_START) ? id : 16'($urandom);
    r.rx_byte = (kind == cpr_pkg::REQ_BYTE) ? b : 8'($urandom);
    camera_req_q.push_back(r);
    reqs_queued++;
  endfunction

  // Queues a start and then the packet's bytes, with ticks and unused request
  // codes scattered between them. A packet cut short stops after cut bytes.
  task automatic queue_packet(input logic [15:0] want, input logic [15:0] sent,
                              input logic [15:0] size, input int fault,
                              input int tick_pct, input int cut);
    logic [7:0]  pkt_bytes[$];
    logic [15:0] sum;
    pkt_bytes.push_back(sent[7:0]);
    pkt_bytes.push_back(sent[15:8]);
    pkt_bytes.push_back(size[7:0]);
    pkt_bytes.push_back(size[15:8]);
    for (int i = 0; i < size; i++) pkt_bytes.push_back(8'($urandom));
    sum = '0;
    for (int i = 0; i < pkt_bytes.size(); i++) sum = sum + {8'h00, pkt_bytes[i]};
    if (fault == FAULT_SUM_LOW) sum[7:0] = sum[7:0] ^ 8'($urandom_range(1, 255));
    if (fault == FAULT_SUM_HIGH) sum[15:8] = sum[15:8] ^ 8'($urandom_range(1, 255));
    pkt_bytes.push_back(sum[7:0]);
    pkt_bytes.push_back(sum[15:8]);
    push_req(cpr_pkg::REQ_START, want, 8'h00);
    for (int i = 0; i < pkt_bytes.size() && i != cut; i++) begin
      while ($urandom_range(0, 99) < tick_pct) push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
      if ($urandom_range(0, 99) < 3) push_req(REQ_UNUSED, 16'h0000, 8'h00);
      push_req(cpr_pkg::REQ_BYTE, 16'h0000, pkt_bytes[i]);
    end
  endtask

  task automatic write_reg(input logic [cpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cpr_pkg::CFG_HEADER_TIMEOUT: hdr_limit = val;
      cpr_pkg::CFG_BODY_TIMEOUT: body_limit = val;
      default: ;
    endcase
  endtask

  // Waits until every queued request is taken and every result has arrived,
  // then lets requests without a result drain out of the pipeline.
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || pkt_result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Request driver: holds each request until accepted, then idles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_request(in_data);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (camera_req_q.size() != 0) begin
          in_data <= camera_req_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    cpr_pkg::cpr_out_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pkt_result_q.size() == 0) begin
          $error("unexpected result: kind %0d, status %0d, data %0h",
                 out_data.kind, out_data.status, out_data.data_byte);
          err_count++;
        end else begin
          due = pkt_result_q.pop_front();
          check_field("kind", 16'(due.kind), 16'(out_data.kind));
          check_field("data_byte", 16'(due.data_byte), 16'(out_data.data_byte));
          check_field("byte_index", due.byte_index, out_data.byte_index);
          check_field("status", 16'(due.status), 16'(out_data.status));
          check_field("payload_length", due.payload_length, out_data.payload_length);
          check_field("last", 16'(due.last), 16'(out_data.last));
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("camera_packet_receiver test failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] hdr;
    logic [15:0] body;
    logic [15:0] want;
    logic [15:0] size;
    logic [15:0] lim;
    logic [1:0]  stray;
    int          target;
    int          r;
    int          cut;
    int          tick_pct;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Requests while idle and the unused code are all ignored.
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hff);
    push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    push_req(REQ_UNUSED, 16'h0000, 8'h00);

    // All-ones id with an empty payload: the checksum follows the header.
    push_req(cpr_pkg::REQ_START, 16'hffff, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hff);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hff);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hfe);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h01);

    // A new start abandons the packet in progress; the new one has a bad sum.
    push_req(cpr_pkg::REQ_START, 16'h1234, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h34);
    push_req(cpr_pkg::REQ_START, 16'h00aa, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'haa);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h01);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h80);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h2b);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);

    // Wrong id, reported after the header with the largest size.
    push_req(cpr_pkg::REQ_START, 16'h5a5a, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h5a);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'ha5);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hff);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hff);
    wait_idle();

    // A zero header limit expires on the first tick; then a body timeout.
    write_reg(cpr_pkg::CFG_HEADER_TIMEOUT, 16'h0000);
    write_reg(cpr_pkg::CFG_BODY_TIMEOUT, 16'h0002);
    push_req(cpr_pkg::REQ_START, 16'h0001, 8'h00);
    push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_START, 16'h0002, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h02);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h01);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h7f);
    push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    wait_idle();

    // One tick short of the header limit, then of the body limit, then the
    // body limit runs out after a payload byte.
    write_reg(cpr_pkg::CFG_HEADER_TIMEOUT, 16'd5);
    write_reg(cpr_pkg::CFG_BODY_TIMEOUT, 16'd6);
    no_idle = 1'b1;
    push_req(cpr_pkg::REQ_START, 16'hbeef, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hef);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'hbe);
    repeat (4) push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h01);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h00);
    repeat (5) push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    push_req(cpr_pkg::REQ_BYTE, 16'h0000, 8'h55);
    push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
    wait_idle();

    // Random phases, each with its own limits and idling style.
    while (reqs_queued < RANDOM_REQS) begin
      r = $urandom_range(0, 9);
      hdr = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : (r == 2) ? 16'h0001
          : 16'($urandom_range(2, 40));
      r = $urandom_range(0, 9);
      body = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : (r == 2) ? 16'h0001
           : 16'($urandom_range(2, 60));
      write_reg(cpr_pkg::CFG_HEADER_TIMEOUT, hdr);
      write_reg(cpr_pkg::CFG_BODY_TIMEOUT, body);
      no_idle = ($urandom_range(0, 3) == 0);
      target = reqs_queued + 80;
      while (reqs_queued < target) begin
        r = $urandom_range(0, 99);
        want = 16'($urandom);
        size = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(200, 300))
             : 16'($urandom_range(0, 12));
        tick_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (r < 58) begin
          queue_packet(want, want, size, FAULT_NONE, tick_pct, NO_CUT);
        end else if (r < 70) begin
          queue_packet(want, want, size,
                       $urandom_range(0, 1) ? FAULT_SUM_LOW : FAULT_SUM_HIGH,
                       tick_pct, NO_CUT);
        end else if (r < 78) begin
          queue_packet(want, want ^ (16'h0001 << $urandom_range(0, 15)), size,
                       FAULT_NONE, tick_pct, NO_CUT);
        end else if (r < 92) begin
          // Truncated packet: the next start abandons it or ticks run it out.
          cut = $urandom_range(0, size + 5);
          queue_packet(want, want, size, FAULT_NONE, tick_pct, cut);
          lim = (cut < 4) ? hdr : body;
          if ($urandom_range(0, 1) == 1 && lim <= 16'd200)
            repeat (lim + 1) push_req(cpr_pkg::REQ_TICK, 16'h0000, 8'h00);
        end else begin
          // Stray requests between packets.
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0: stray = cpr_pkg::REQ_BYTE;
              1: stray = cpr_pkg::REQ_TICK;
              default: stray = REQ_UNUSED;
            endcase
            push_req(stray, 16'($urandom), 8'($urandom));
          end
        end
      end
      wait_idle();
    end

    if (err_count == 0)
      $display("camera_packet_receiver test passed");
    else
      $display("camera_packet_receiver test failed");
    $finish;
  end

endmodule
